>>> hw/rtl/plp_pkg.sv
// Shared constants, types and arithmetic helpers for the polar point histogram.
package plp_pkg;

   localparam int NUM_BINS    = 100;
   localparam int COUNT_WIDTH = 16;
   localparam int SIDE        = NUM_BINS + 1;
   localparam int CELLS       = SIDE * SIDE;
   localparam int BIN_W       = $clog2(SIDE);
   localparam int ADDR_W      = $clog2(CELLS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Sine polynomial coefficients, Q4.14
   localparam logic signed [17:0] COEF_T = 18'sd1160;
   localparam logic signed [17:0] COEF_U = 18'sd10512;
   localparam logic signed [17:0] COEF_W = 18'sd25736;
   localparam logic signed [17:0] HALF   = 18'sd16384;

   // Multiplier step numbers of one sine-to-bin pass
   localparam logic [2:0] STEP_SQUARE = 3'd0;
   localparam logic [2:0] STEP_T      = 3'd1;
   localparam logic [2:0] STEP_V      = 3'd2;
   localparam logic [2:0] STEP_SINE   = 3'd3;
   localparam logic [2:0] STEP_RADIUS = 3'd4;
   localparam logic [2:0] STEP_BIN    = 3'd5;

   // Command codes
   localparam logic [1:0] CMD_ADD       = 2'd0;
   localparam logic [1:0] CMD_READ      = 2'd1;
   localparam logic [1:0] CMD_READ_CLR  = 2'd2;
   localparam logic [1:0] CMD_UNUSED    = 2'd3;

   typedef struct packed {
      logic             add;
      logic             clear;
      logic [BIN_W-1:0] col;
      logic [BIN_W-1:0] row;
   } job_type;

   // Fold a Q1.15 angle into [-1/2, 1/2] of pi
   function automatic logic signed [17:0] fold_angle(input logic signed [15:0] a);
      logic signed [17:0] ax;
      ax = 18'(a);
      if (ax > HALF) begin
         return 18'sd32768 - ax;
      end else if (ax < -HALF) begin
         return -18'sd32768 - ax;
      end
      return ax;
   endfunction

   // Clamp a bin request to the top bin
   function automatic logic [BIN_W-1:0] clamp_bin(input logic [6:0] v);
      if (8'(v) > 8'(NUM_BINS)) begin
         return BIN_W'(NUM_BINS);
      end
      return BIN_W'(v);
   endfunction

   // Report a counter through the 16-bit count field
   function automatic logic [15:0] report_count(input logic [COUNT_WIDTH-1:0] v);
      logic [32:0] e;
      e = 33'(v);
      if (e > 33'h0FFFF) begin
         return 16'hFFFF;
      end
      return e[15:0];
   endfunction

endpackage

>>> hw/rtl/plp_front.sv
// Front end: accepts commands and turns add points into cell coordinates.
module plp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    hold,
   input  logic                    push,
   output logic                    full,
   input  logic [1:0]              req_command,
   input  logic signed [15:0]      req_angle,
   input  logic [15:0]             req_radius,
   input  logic [6:0]              req_cell_column,
   input  logic [6:0]              req_cell_row,
   output logic                    q_push,
   input  logic                    q_full,
   output plp_pkg::job_type        q_data
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CALC = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   fstate_type               state_ff, state_in;
   logic [2:0]               step_ff, step_in;
   logic                     pass_ff, pass_in;
   logic signed [15:0]       angle_ff, angle_in;
   logic [15:0]              radius_ff, radius_in;
   logic signed [17:0]       z_ff, z_in;
   logic signed [17:0]       z2_ff, z2_in;
   logic signed [17:0]       acc_ff, acc_in;
   plp_pkg::job_type         job_ff, job_in;
   logic signed [17:0]       mul_a, mul_b;
   logic signed [35:0]       prod;
   logic signed [35:0]       sh14, sh15, sh16;
   logic signed [35:0]       coord;
   logic [plp_pkg::BIN_W-1:0] bin;
   logic                     accept;

   assign full   = (state_ff != F_IDLE) || hold;
   assign accept = push && !full;
   assign q_push = (state_ff == F_PUSH) && !q_full;
   assign q_data = job_ff;

   // Select multiplier operands for the current step
   always_comb begin
      mul_a = (step_ff == plp_pkg::STEP_SQUARE) ? z_ff : acc_ff;
      unique case (step_ff)
         plp_pkg::STEP_SQUARE: mul_b = z_ff;
         plp_pkg::STEP_T:      mul_b = plp_pkg::COEF_T;
         plp_pkg::STEP_V:      mul_b = z2_ff;
         plp_pkg::STEP_SINE:   mul_b = z_ff;
         plp_pkg::STEP_RADIUS: mul_b = 18'({2'b00, radius_ff});
         default:              mul_b = 18'(plp_pkg::NUM_BINS);
      endcase
   end

   assign prod  = 36'(mul_a) * 36'(mul_b);
   assign sh14  = prod >>> 14;
   assign sh15  = prod >>> 15;
   assign sh16  = prod >>> 16;
   assign coord = sh16 + 36'sd16384;
   assign bin   = (sh15 > 36'(plp_pkg::NUM_BINS)) ? plp_pkg::BIN_W'(plp_pkg::NUM_BINS)
                                                   : plp_pkg::BIN_W'(sh15);

   // Sequence accept, multiplier passes and queue push
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      pass_in   = pass_ff;
      angle_in  = angle_ff;
      radius_in = radius_ff;
      z_in      = z_ff;
      z2_in     = z2_ff;
      acc_in    = acc_ff;
      job_in    = job_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               angle_in    = req_angle;
               radius_in   = req_radius;
               job_in.add  = (req_command == plp_pkg::CMD_ADD);
               job_in.clear = (req_command == plp_pkg::CMD_READ_CLR);
               job_in.col  = plp_pkg::clamp_bin(req_cell_column);
               job_in.row  = plp_pkg::clamp_bin(req_cell_row);
               step_in     = plp_pkg::STEP_SQUARE;
               pass_in     = 1'b0;
               // cosine first: sine of angle plus a half, wrapped
               z_in        = plp_pkg::fold_angle(req_angle + 16'sd16384);
               state_in    = (req_command == plp_pkg::CMD_ADD) ? F_CALC : F_PUSH;
            end
         end
         F_CALC: begin
            step_in = step_ff + 3'd1;
            unique case (step_ff)
               plp_pkg::STEP_SQUARE: begin
                  z2_in  = 18'(sh14);
                  acc_in = 18'(sh14);
               end
               plp_pkg::STEP_T: acc_in = plp_pkg::COEF_U - 18'(sh14);
               plp_pkg::STEP_V: acc_in = plp_pkg::COEF_W - 18'(sh14);
               plp_pkg::STEP_SINE: begin
                  if (sh14 > 36'sd16384) begin
                     acc_in = plp_pkg::HALF;
                  end else if (sh14 < -36'sd16384) begin
                     acc_in = -plp_pkg::HALF;
                  end else begin
                     acc_in = 18'(sh14);
                  end
               end
               plp_pkg::STEP_RADIUS: acc_in = (coord < 0) ? 18'sd0 : 18'(coord);
               default: begin
                  step_in = plp_pkg::STEP_SQUARE;
                  if (!pass_ff) begin
                     job_in.col = bin;
                     pass_in    = 1'b1;
                     z_in       = plp_pkg::fold_angle(angle_ff);
                  end else begin
                     job_in.row = bin;
                     state_in   = F_PUSH;
                  end
               end
            endcase
         end
         default: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= plp_pkg::STEP_SQUARE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         pass_ff  <= pass_in;
      end
      angle_ff  <= angle_in;
      radius_ff <= radius_in;
      z_ff      <= z_in;
      z2_ff     <= z2_in;
      acc_ff    <= acc_in;
      job_ff    <= job_in;
   end

   // Step counter never passes the bin step
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= plp_pkg::STEP_BIN)
      else $error("front step out of range");

   // A pass ends back at the square step
   a_step_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_CALC && step_ff == plp_pkg::STEP_BIN) |=> step_ff == plp_pkg::STEP_SQUARE)
      else $error("front step did not wrap");

   // Read commands skip the multiplier
   a_read_direct: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command != plp_pkg::CMD_ADD) |=> state_ff == F_PUSH)
      else $error("read command entered calculation");

endmodule

>>> hw/rtl/plp_queue.sv
// Short job queue between the front end and the counter back end.
module plp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  plp_pkg::job_type wr_data,
   output logic             q_full,
   input  logic             rd_en,
   output logic             q_empty,
   output plp_pkg::job_type rd_data
);

   plp_pkg::job_type              slot_ff [plp_pkg::QUEUE_DEPTH];
   logic [plp_pkg::QPTR_W-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [plp_pkg::QPTR_W:0]      cnt_ff, cnt_in;
   logic                          do_wr, do_rd;

   assign q_full  = (cnt_ff == (plp_pkg::QPTR_W+1)'(plp_pkg::QUEUE_DEPTH));
   assign q_empty = (cnt_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = slot_ff[rp_ff];

   // Advance pointers and occupancy
   always_comb begin
      wp_in  = do_wr ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_rd ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (plp_pkg::QPTR_W+1)'(do_wr) - (plp_pkg::QPTR_W+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_wr) begin
         slot_ff[wp_ff] <= wr_data;
      end
   end

   // Occupancy stays within depth
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (plp_pkg::QPTR_W+1)'(plp_pkg::QUEUE_DEPTH))
      else $error("queue overfilled");

   // Pointer gap matches occupancy
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wp_ff - rp_ff) == cnt_ff[plp_pkg::QPTR_W-1:0])
      else $error("queue pointers disagree with count");

   // A lone write raises occupancy by one
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (do_wr && !do_rd) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count did not advance");

endmodule

>>> hw/rtl/plp_back.sv
// Back end: counter memory with clear sweep, read-modify-write and result register.
module plp_back (
   input  logic                    clock,
   input  logic                    reset,
   output logic                    clearing,
   input  logic                    q_empty,
   output logic                    q_pop,
   input  plp_pkg::job_type        q_data,
   output logic                    empty,
   input  logic                    pop,
   output logic [6:0]              rsp_column_bin,
   output logic [6:0]              rsp_row_bin,
   output logic [15:0]             rsp_count,
   output logic                    rsp_saturated
);

   typedef enum logic [2:0] {
      B_CLEAR = 3'b001,
      B_IDLE  = 3'b010,
      B_WAIT  = 3'b100
   } bstate_type;

   logic [plp_pkg::COUNT_WIDTH-1:0] mem [plp_pkg::CELLS];

   bstate_type                      state_ff, state_in;
   logic [plp_pkg::ADDR_W-1:0]      clr_ff, clr_in;
   logic [plp_pkg::ADDR_W-1:0]      addr_ff, rd_addr, wr_addr;
   logic [plp_pkg::COUNT_WIDTH-1:0] rd_data_ff, wr_data, next_cnt;
   plp_pkg::job_type                job_ff;
   logic                            we, full_hit;
   logic                            out_valid_ff, out_valid_in;
   logic [6:0]                      col_ff, row_ff;
   logic [15:0]                     count_ff;
   logic                            sat_ff;

   assign clearing = (state_ff == B_CLEAR);
   assign q_pop    = (state_ff == B_IDLE) && !q_empty && !out_valid_ff;
   assign rd_addr  = plp_pkg::ADDR_W'(q_data.col) * plp_pkg::ADDR_W'(plp_pkg::SIDE)
                   + plp_pkg::ADDR_W'(q_data.row);
   assign full_hit = (rd_data_ff == plp_pkg::COUNT_MAX);
   assign next_cnt = full_hit ? rd_data_ff : rd_data_ff + 1'b1;

   // Pick the write: sweep zero, add result or clear after read
   always_comb begin
      we      = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      unique case (state_ff)
         B_CLEAR: begin
            we      = 1'b1;
            wr_addr = clr_ff;
         end
         B_WAIT: begin
            we      = job_ff.add || job_ff.clear;
            wr_data = job_ff.add ? next_cnt : '0;
         end
         default: we = 1'b0;
      endcase
   end

   // Sequence sweep, launch and finish
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      out_valid_in = out_valid_ff && !pop;
      unique case (state_ff)
         B_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == plp_pkg::ADDR_W'(plp_pkg::CELLS - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (q_pop) begin
               state_in = B_WAIT;
            end
         end
         default: begin
            state_in     = B_IDLE;
            out_valid_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Counter memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Latch the job and load the result register
   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff  <= q_data;
         addr_ff <= rd_addr;
      end
      if (state_ff == B_WAIT) begin
         col_ff   <= 7'(job_ff.col);
         row_ff   <= 7'(job_ff.row);
         count_ff <= plp_pkg::report_count(job_ff.add ? next_cnt : rd_data_ff);
         sat_ff   <= job_ff.add && full_hit;
      end
   end

   assign empty          = !out_valid_ff;
   assign rsp_column_bin = col_ff;
   assign rsp_row_bin    = row_ff;
   assign rsp_count      = count_ff;
   assign rsp_saturated  = sat_ff;

   // No result appears during the sweep
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !out_valid_ff)
      else $error("result during clear sweep");

   // A launched job finishes with a result next cycle
   a_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_WAIT) |=> out_valid_ff)
      else $error("job finished without result");

   // Saturation only on adds
   a_sat_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_WAIT && !job_ff.add) |=> !sat_ff)
      else $error("saturation flag on read");

endmodule

>>> hw/rtl/polar_point_histogram_2d.sv
// Top level of the polar point two-dimensional histogram.
//
// Input channel: push/full with req_command, req_angle, req_radius,
// req_cell_column, req_cell_row; a transaction completes when push is high
// and full is low. Result channel: empty/pop with rsp_column_bin,
// rsp_row_bin, rsp_count, rsp_saturated; the oldest result is shown while
// empty is low and leaves when pop is high.
// Each command gives exactly one result, in order.
// An add runs two six-step passes (cosine then sine, each ending in a bin)
// through one shared 18x18 multiplier in the front end; reads skip them.
// Each back-end job runs the registered counter memory read, the write back
// with the result load, and the pop; the next job leaves the queue only
// once the result is popped. The front end takes no new command until its
// job is pushed into the queue.
// After reset the counter memory is swept to zero, one cell per cycle, over
// all 10201 cells; full stays high until the sweep ends.
// When the receiver stalls, the result register holds, the four-entry job
// queue fills and then full rises.
module polar_point_histogram_2d (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_command,
   input  logic signed [15:0] req_angle,
   input  logic [15:0]        req_radius,
   input  logic [6:0]         req_cell_column,
   input  logic [6:0]         req_cell_row,
   output logic               empty,
   input  logic               pop,
   output logic [6:0]         rsp_column_bin,
   output logic [6:0]         rsp_row_bin,
   output logic [15:0]        rsp_count,
   output logic               rsp_saturated
);

   logic             clearing;
   logic             q_push, q_full, q_pop, q_empty;
   plp_pkg::job_type q_wr_data, q_rd_data;

   plp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .hold            (clearing),
      .push            (push),
      .full            (full),
      .req_command     (req_command),
      .req_angle       (req_angle),
      .req_radius      (req_radius),
      .req_cell_column (req_cell_column),
      .req_cell_row    (req_cell_row),
      .q_push          (q_push),
      .q_full          (q_full),
      .q_data          (q_wr_data)
   );

   plp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .q_empty (q_empty),
      .rd_data (q_rd_data)
   );

   plp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .clearing       (clearing),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .q_data         (q_rd_data),
      .empty          (empty),
      .pop            (pop),
      .rsp_column_bin (rsp_column_bin),
      .rsp_row_bin    (rsp_row_bin),
      .rsp_count      (rsp_count),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

>>> bench/tb_polar_point_histogram_2d.sv
// Testbench for the polar point 2-D histogram: directed and randomized commands checked against a predictor.
`timescale 1ns / 1ps

module tb_polar_point_histogram_2d;

   typedef struct {
      logic [6:0]  column_bin;
      logic [6:0]  row_bin;
      logic [15:0] count;
      logic        saturated;
   } bin_result_type;

   // Histogram predictor and store of expected results
   class histogram_scoreboard_type;
      int unsigned    cell_counts[plp_pkg::CELLS];
      bin_result_type pending_results[$];
      int             mismatches;

      function new();
         foreach (cell_counts[i]) cell_counts[i] = 0;
         mismatches = 0;
      endfunction

      function longint floor_div(longint v, int n);
         return v >>> n;
      endfunction

      function longint sine_q14(longint a);
         longint z, z2, t, u, v, w, s;
         if (a > 16384) a = 32768 - a;
         else if (a < -16384) a = -32768 - a;
         z  = a;
         z2 = floor_div(z * z, 14);
         t  = floor_div(1160 * z2, 14);
         u  = 10512 - t;
         v  = floor_div(u * z2, 14);
         w  = 25736 - v;
         s  = floor_div(z * w, 14);
         if (s > 16384) s = 16384;
         if (s < -16384) s = -16384;
         return s;
      endfunction

      function int coord_to_bin(longint coord);
         longint shifted, b;
         shifted = coord + 16384;
         if (shifted < 0) shifted = 0;
         b = (shifted * plp_pkg::NUM_BINS) >> 15;
         if (b > plp_pkg::NUM_BINS) b = plp_pkg::NUM_BINS;
         return int'(b);
      endfunction

      // Note one accepted transaction and predict its result
      function void note_command(logic [1:0] cmd, logic signed [15:0] angle,
                                 logic [15:0] radius, logic [6:0] ccol, logic [6:0] crow);
         bin_result_type r;
         int col, row, idx;
         longint a, ac;
         int unsigned cnt;
         logic signed [15:0] a_cos;
         r.saturated = 1'b0;
         if (cmd == plp_pkg::CMD_ADD) begin
            a     = angle;
            a_cos = angle + 16'sd16384;
            ac    = a_cos;
            col = coord_to_bin(floor_div(longint'(radius) * sine_q14(ac), 16));
            row = coord_to_bin(floor_div(longint'(radius) * sine_q14(a), 16));
            idx = col * plp_pkg::SIDE + row;
            if (cell_counts[idx] >= plp_pkg::COUNT_MAX) begin
               cell_counts[idx] = plp_pkg::COUNT_MAX;
               r.saturated = 1'b1;
            end else begin
               cell_counts[idx]++;
            end
            cnt = cell_counts[idx];
         end else begin
            col = (ccol > plp_pkg::NUM_BINS) ? plp_pkg::NUM_BINS : ccol;
            row = (crow > plp_pkg::NUM_BINS) ? plp_pkg::NUM_BINS : crow;
            idx = col * plp_pkg::SIDE + row;
            cnt = cell_counts[idx];
            if (cmd == plp_pkg::CMD_READ_CLR) cell_counts[idx] = 0;
         end
         if (cnt > 16'hFFFF) cnt = 16'hFFFF;
         r.column_bin = 7'(col);
         r.row_bin    = 7'(row);
         r.count      = 16'(cnt);
         pending_results.push_back(r);
      endfunction

      // Compare one accepted result with the oldest expectation
      task check_result(bin_result_type got);
         bin_result_type exp_r;
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected", 0, 0);
            return;
         end
         exp_r = pending_results.pop_front();
         if (got.column_bin !== exp_r.column_bin)
            report_mismatch("column_bin", got.column_bin, exp_r.column_bin);
         if (got.row_bin !== exp_r.row_bin)
            report_mismatch("row_bin", got.row_bin, exp_r.row_bin);
         if (got.count !== exp_r.count)
            report_mismatch("count", got.count, exp_r.count);
         if (got.saturated !== exp_r.saturated)
            report_mismatch("saturated", got.saturated, exp_r.saturated);
      endtask

      task report_mismatch(string what, longint got, longint want);
         $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
         mismatches++;
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic [1:0]         req_command = plp_pkg::CMD_ADD;
   logic signed [15:0] req_angle = '0;
   logic [15:0]        req_radius = '0;
   logic [6:0]         req_cell_column = '0;
   logic [6:0]         req_cell_row = '0;
   logic               empty;
   logic               pop = 1'b0;
   logic [6:0]         rsp_column_bin;
   logic [6:0]         rsp_row_bin;
   logic [15:0]        rsp_count;
   logic               rsp_saturated;

   histogram_scoreboard_type scoreboard = new();
   int  cycle_count = 0;
   bit  hold_off = 1'b0;

   polar_point_histogram_2d dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hold the cycle limit: the sweep plus every add with stalls, many times over
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 900000) begin
         $display("polar_point_histogram_2d regression: fail");
         $finish;
      end
   end

   // Accept results and check them
   always @(posedge clock) begin
      bin_result_type got;
      if (!reset && pop && !empty) begin
         got.column_bin = rsp_column_bin;
         got.row_bin    = rsp_row_bin;
         got.count      = rsp_count;
         got.saturated  = rsp_saturated;
         scoreboard.check_result(got);
      end
   end

   // Stall the receiver on its own pattern, with a long hold-off on request
   always @(posedge clock) begin
      int phase;
      phase = cycle_count % 200;
      if (hold_off) pop <= 1'b0;
      else if (phase < 60) pop <= 1'b1;
      else pop <= ($urandom_range(0, 3) != 0);
   end

   // Offer one transaction and wait until it is accepted
   task automatic send_command(logic [1:0] cmd, logic signed [15:0] angle,
                               logic [15:0] radius, logic [6:0] ccol, logic [6:0] crow);
      push            <= 1'b1;
      req_command     <= cmd;
      req_angle       <= angle;
      req_radius      <= radius;
      req_cell_column <= ccol;
      req_cell_row    <= crow;
      do @(posedge clock); while (full);
      scoreboard.note_command(cmd, angle, radius, ccol, crow);
   endtask

   task automatic idle_cycles(int n);
      push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_random();
      int pick;
      logic [1:0] cmd;
      pick = $urandom_range(0, 9);
      cmd = (pick < 6) ? plp_pkg::CMD_ADD : (pick < 8) ? plp_pkg::CMD_READ :
            (pick < 9) ? plp_pkg::CMD_READ_CLR : plp_pkg::CMD_UNUSED;
      if ($urandom_range(0, 3) == 0)
         send_command(cmd, 16'($urandom), 16'($urandom), 7'($urandom), 7'($urandom));
      else
         send_command(cmd, 16'($urandom), 16'($urandom), 7'($urandom_range(0, 100)),
                      7'($urandom_range(0, 100)));
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (scoreboard.pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic signed [15:0] angles[8];
      int wait_count;
      angles = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh4000, 16'shC000, 16'sh2000,
                 16'shBFFF, 16'sh4001};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: angle and radius extremes, reads, clear, unused code, index clamps
      foreach (angles[i]) send_command(plp_pkg::CMD_ADD, angles[i], 16'hFFFF, 7'd0, 7'd0);
      send_command(plp_pkg::CMD_ADD, 16'sh1234, 16'h0000, 7'h7F, 7'h7F);
      send_command(plp_pkg::CMD_ADD, 16'sh1234, 16'h0000, 7'h7F, 7'h7F);
      send_command(plp_pkg::CMD_READ, '0, '0, 7'd50, 7'd50);
      send_command(plp_pkg::CMD_READ_CLR, '0, '0, 7'd50, 7'd50);
      send_command(plp_pkg::CMD_READ, '0, '0, 7'd50, 7'd50);
      send_command(plp_pkg::CMD_UNUSED, '0, '0, 7'd100, 7'd0);
      send_command(plp_pkg::CMD_READ, '0, '0, 7'h7F, 7'd101);
      send_command(plp_pkg::CMD_READ_CLR, '0, '0, 7'd0, 7'h7F);
      send_command(plp_pkg::CMD_READ, '0, '0, 7'd0, 7'd0);
      wait_drained();

      // Long receiver hold-off while the sender keeps offering
      hold_off = 1'b1;
      fork
         repeat (12) send_random();
         begin
            wait_count = 0;
            while (wait_count < 400) begin
               @(posedge clock);
               wait_count++;
            end
            hold_off = 1'b0;
         end
      join
      wait_drained();

      // Random bursts with random gaps
      for (int sent = 0; sent < 480;) begin
         int burst;
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst; k++) begin
            send_random();
            sent++;
         end
         if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 40));
      end
      wait_drained();
      repeat (50) @(posedge clock);

      if (scoreboard.mismatches == 0 && scoreboard.pending_results.size() == 0)
         $display("polar_point_histogram_2d regression: pass");
      else
         $display("polar_point_histogram_2d regression: fail");
      $finish;
   end

endmodule
